// ----- src/cfr_pkg.sv -----
// Shared types, constants and CRC helper for the COBS/CRC frame receiver.
package cfr_pkg;

   localparam int RAW_DEPTH     = 512;
   localparam int DECODED_DEPTH = 512;
   localparam int RAW_AW        = $clog2(RAW_DEPTH);
   localparam int RAW_CW        = $clog2(RAW_DEPTH + 1);
   localparam int DEC_AW        = $clog2(DECODED_DEPTH);
   localparam int DEC_CW        = $clog2(DECODED_DEPTH + 1);
   localparam int IDX_W         = 9;
   localparam int POS_W         = ((DEC_AW > IDX_W) ? DEC_AW : IDX_W) + 1;
   localparam int HDR_BYTES     = 7;
   localparam int MIN_FRAME     = 9;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [7:0]  CODE_MAX = 8'hFF;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_OVERFLOW = 3'd1;
   localparam logic [2:0] ST_COBS     = 3'd2;
   localparam logic [2:0] ST_CRC      = 3'd3;
   localparam logic [2:0] ST_LENGTH   = 3'd4;
   localparam logic [2:0] ST_VERSION  = 3'd5;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [7:0]       line_byte;
      logic [IDX_W-1:0] payload_index;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [2:0]  status;
      logic [7:0]  frame_type;
      logic [7:0]  channel;
      logic [15:0] sequence_res;
      logic [8:0]  payload_length;
      logic [7:0]  read_data;
      logic [31:0] ok_count;
      logic [31:0] overflow_count;
      logic [31:0] cobs_error_count;
      logic [31:0] check_error_count;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic dec_start;
      logic fetch;
      logic proc;
      logic zfill;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic raw_empty;
      logic ovf;
      logic rp_at_end;
      logic fail;
      logic proc_to_z;
      logic rsp_free;
   } sts_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
         else c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ----- src/cfr_ctrl.sv -----
// Sequencer for byte intake, COBS decode walk and result loading.
module cfr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cfr_pkg::req_type req_item,
   input  cfr_pkg::sts_type sts,
   output cfr_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {S_IDLE, S_FETCH, S_PROC, S_ZFILL, S_RESP} state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_item.mode) begin
                  state_in = S_RESP;
               end else if (req_item.line_byte == 8'h00 && !sts.raw_empty) begin
                  if (sts.ovf) begin
                     state_in = S_RESP;
                  end else begin
                     cmd.dec_start = 1'b1;
                     state_in      = S_FETCH;
                  end
               end
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            if (sts.fail || sts.rp_at_end) state_in = S_RESP;
            else state_in = S_PROC;
         end
         S_PROC: begin
            cmd.proc = 1'b1;
            state_in = sts.proc_to_z ? S_ZFILL : S_FETCH;
         end
         S_ZFILL: begin
            cmd.zfill = 1'b1;
            state_in  = S_FETCH;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ----- src/cfr_datapath.sv -----
// Raw and decoded stores, decode pointers, running CRC, counters, result register.
module cfr_datapath (
   input  logic             clock,
   input  logic             reset,
   input  cfr_pkg::req_type req_item,
   input  cfr_pkg::cmd_type cmd,
   output cfr_pkg::sts_type sts,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cfr_pkg::rsp_type rsp_item
);

   logic [7:0] raw_mem [cfr_pkg::RAW_DEPTH];
   logic [7:0] dec_mem [cfr_pkg::DECODED_DEPTH];

   logic [cfr_pkg::RAW_CW-1:0] raw_count_ff, rp_ff;
   logic [cfr_pkg::DEC_CW-1:0] wp_ff;
   logic                       ovf_ff, fail_ff, kind_ff, rd_oob_ff, rsp_valid_ff;
   logic [7:0]                 raw_rd_ff, dec_rd_ff, remain_ff, code_ff, ver_ff, w0_ff, w1_ff;
   logic [7:0]                 hdr_ff [cfr_pkg::HDR_BYTES];
   logic [15:0]                crc_ff;
   logic [31:0]                ok_ff, ovc_ff, cobs_ff, chk_ff;
   cfr_pkg::rsp_type           rsp_ff, rsp_in;

   logic [cfr_pkg::POS_W-1:0] pos;
   logic                      wr_en, fail_set;
   logic [7:0]                wr_data, d;
   logic [2:0]                fstat;
   logic [16:0]               len_sum;

   assign d   = raw_rd_ff;
   assign pos = cfr_pkg::POS_W'(req_item.payload_index) + cfr_pkg::POS_W'(cfr_pkg::HDR_BYTES);

   assign sts.raw_empty = (raw_count_ff == '0);
   assign sts.ovf       = ovf_ff;
   assign sts.rp_at_end = (rp_ff == raw_count_ff);
   assign sts.fail      = fail_ff;
   assign sts.proc_to_z = (remain_ff == 8'd0) ? (d == 8'd1) : (remain_ff == 8'd1);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   // decode step: write enable/data and failure detection
   always_comb begin
      wr_en    = 1'b0;
      wr_data  = d;
      fail_set = 1'b0;
      if (cmd.fetch && sts.rp_at_end && remain_ff != 8'd0) fail_set = 1'b1;
      if (cmd.proc) begin
         if (remain_ff == 8'd0) begin
            if (d == 8'd0) fail_set = 1'b1;
         end else if (wp_ff == cfr_pkg::DEC_CW'(cfr_pkg::DECODED_DEPTH)) begin
            fail_set = 1'b1;
         end else begin
            wr_en = 1'b1;
         end
      end
      if (cmd.zfill && !fail_ff && code_ff != cfr_pkg::CODE_MAX && !sts.rp_at_end) begin
         wr_data = 8'h00;
         if (wp_ff == cfr_pkg::DEC_CW'(cfr_pkg::DECODED_DEPTH)) fail_set = 1'b1;
         else wr_en = 1'b1;
      end
   end

   // frame verdict
   always_comb begin
      len_sum = {1'b0, hdr_ff[6], hdr_ff[5]} + 17'(cfr_pkg::MIN_FRAME);
      if (ovf_ff) fstat = cfr_pkg::ST_OVERFLOW;
      else if (fail_ff || wp_ff < cfr_pkg::DEC_CW'(cfr_pkg::MIN_FRAME)) fstat = cfr_pkg::ST_COBS;
      else if ({w0_ff, w1_ff} != crc_ff) fstat = cfr_pkg::ST_CRC;
      else if (len_sum != 17'(wp_ff)) fstat = cfr_pkg::ST_LENGTH;
      else if (hdr_ff[0] != ver_ff) fstat = cfr_pkg::ST_VERSION;
      else fstat = cfr_pkg::ST_OK;
   end

   always_comb begin
      rsp_in                   = '0;
      rsp_in.ok_count          = ok_ff;
      rsp_in.overflow_count    = ovc_ff;
      rsp_in.cobs_error_count  = cobs_ff;
      rsp_in.check_error_count = chk_ff;
      if (kind_ff == cfr_pkg::KIND_READ) begin
         rsp_in.result_kind = cfr_pkg::KIND_READ;
         rsp_in.read_data   = rd_oob_ff ? 8'h00 : dec_rd_ff;
      end else begin
         rsp_in.status = fstat;
         case (fstat)
            cfr_pkg::ST_OK: begin
               rsp_in.ok_count       = ok_ff + 32'd1;
               rsp_in.frame_type     = hdr_ff[1];
               rsp_in.channel        = hdr_ff[2];
               rsp_in.sequence_res   = {hdr_ff[4], hdr_ff[3]};
               rsp_in.payload_length = {hdr_ff[6][0], hdr_ff[5]};
            end
            cfr_pkg::ST_OVERFLOW: rsp_in.overflow_count = ovc_ff + 32'd1;
            cfr_pkg::ST_COBS: rsp_in.cobs_error_count = cobs_ff + 32'd1;
            default: rsp_in.check_error_count = chk_ff + 32'd1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && !req_item.mode && req_item.line_byte != 8'h00
          && raw_count_ff != cfr_pkg::RAW_CW'(cfr_pkg::RAW_DEPTH))
         raw_mem[raw_count_ff[cfr_pkg::RAW_AW-1:0]] <= req_item.line_byte;
      if (cmd.fetch) raw_rd_ff <= raw_mem[rp_ff[cfr_pkg::RAW_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_en) dec_mem[wp_ff[cfr_pkg::DEC_AW-1:0]] <= wr_data;
      if (cmd.take && req_item.mode) dec_rd_ff <= dec_mem[pos[cfr_pkg::DEC_AW-1:0]];
   end

   // payload-side registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff   <= req_item.mode;
         rd_oob_ff <= (pos >= cfr_pkg::POS_W'(cfr_pkg::DECODED_DEPTH));
      end
      if (cmd.dec_start) begin
         rp_ff     <= '0;
         wp_ff     <= '0;
         remain_ff <= 8'd0;
         fail_ff   <= 1'b0;
         crc_ff    <= cfr_pkg::CRC_INIT;
      end
      if (fail_set) fail_ff <= 1'b1;
      if (cmd.proc) begin
         rp_ff <= rp_ff + 1'b1;
         if (remain_ff == 8'd0) begin
            code_ff   <= d;
            remain_ff <= d - 8'd1;
         end else if (wr_en) begin
            remain_ff <= remain_ff - 8'd1;
         end
      end
      if (wr_en) begin
         wp_ff <= wp_ff + 1'b1;
         if (wp_ff < cfr_pkg::DEC_CW'(cfr_pkg::HDR_BYTES)) hdr_ff[wp_ff[2:0]] <= wr_data;
         // crc trails the write pointer by two bytes, leaving the trailer out
         if (wp_ff >= cfr_pkg::DEC_CW'(2)) crc_ff <= cfr_pkg::crc_byte(crc_ff, w1_ff);
         w1_ff <= w0_ff;
         w0_ff <= wr_data;
      end
      if (cmd.load) rsp_ff <= rsp_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_count_ff <= '0;
         ovf_ff       <= 1'b0;
         ok_ff        <= '0;
         ovc_ff       <= '0;
         cobs_ff      <= '0;
         chk_ff       <= '0;
         ver_ff       <= 8'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) ver_ff <= csr_wr_data;
         if (cmd.take && !req_item.mode) begin
            if (req_item.line_byte != 8'h00) begin
               if (raw_count_ff != cfr_pkg::RAW_CW'(cfr_pkg::RAW_DEPTH))
                  raw_count_ff <= raw_count_ff + 1'b1;
               else
                  ovf_ff <= 1'b1;
            end else if (raw_count_ff == '0) begin
               ovf_ff <= 1'b0;
            end
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
            ok_ff        <= rsp_in.ok_count;
            ovc_ff       <= rsp_in.overflow_count;
            cobs_ff      <= rsp_in.cobs_error_count;
            chk_ff       <= rsp_in.check_error_count;
            if (kind_ff == cfr_pkg::KIND_STATUS) begin
               raw_count_ff <= '0;
               ovf_ff       <= 1'b0;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// ----- src/cobs_crc_frame_receiver_unit.sv -----
// Top level of the COBS deframer with CRC-16/CCITT-FALSE check.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_item (mode, line_byte, payload_index)
//   rsp      out        rsp_valid/rsp_ready    rsp_item (status or read data, counters)
//   csr      in         csr_wr_en              csr_wr_data (protocol_version)
//
// A non-delimiter byte, or an empty delimiter, is taken in the idle state alone; a read or an
// overflowed frame goes on to the result load. A well-formed block passes through the accept,
// a fetch and a process step per stored byte, an end-of-run step per code byte, the final
// fetch and the status load. Reset is synchronous; stores need no clearing. A result waiting
// in the output register holds the sequencer before its next load, and req_ready stays low
// until it drains.
module cobs_crc_frame_receiver_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cfr_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cfr_pkg::rsp_type rsp_item,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data
);

   cfr_pkg::cmd_type cmd;
   cfr_pkg::sts_type sts;

   cfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .sts       (sts),
      .cmd       (cmd)
   );

   cfr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .cmd         (cmd),
      .sts         (sts),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item)
   );

endmodule

// ----- tb/cobs_crc_frame_receiver_unit_tb.sv -----
// Self-checking testbench for the COBS/CRC frame receiver unit.
module cobs_crc_frame_receiver_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 800000;
   localparam int SETTLE      = 24;
   localparam int NUM_ITEMS   = 1900;

   typedef enum {FR_GOOD, FR_CRC, FR_TRUNC, FR_SHORT} frame_kind_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   cfr_pkg::req_type req_item = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   cfr_pkg::rsp_type rsp_item;
   logic             csr_wr_en = 1'b0;
   logic [7:0]       csr_wr_data = '0;

   cobs_crc_frame_receiver_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver-side copy of the block state
   logic [7:0]  raw_mem [cfr_pkg::RAW_DEPTH];
   int          raw_fill;
   bit          raw_ovf;
   logic [7:0]  dec_mem [cfr_pkg::DECODED_DEPTH];
   bit          dec_written [cfr_pkg::DECODED_DEPTH];
   logic [31:0] ok_tot, ovf_tot, cobs_tot, check_tot;
   logic [7:0]  version_reg;

   cfr_pkg::rsp_type expected_rsp [$];
   int      errors = 0;
   int      sent = 0;
   int      burst_left = 0;
   int      hold_left = 0;
   bit      ready_fast = 1'b0;
   int      cycles = 0;

   function automatic int unstuff_block();
      int rp, wp, code;
      rp = 0;
      wp = 0;
      while (rp < raw_fill) begin
         code = int'(raw_mem[rp]);
         rp++;
         if (code == 0) return 0;
         for (int i = 1; i < code; i++) begin
            if (rp >= raw_fill || wp >= cfr_pkg::DECODED_DEPTH) return 0;
            dec_mem[wp] = raw_mem[rp];
            dec_written[wp] = 1'b1;
            rp++;
            wp++;
         end
         if (code < int'(cfr_pkg::CODE_MAX) && rp < raw_fill) begin
            if (wp >= cfr_pkg::DECODED_DEPTH) return 0;
            dec_mem[wp] = 8'h00;
            dec_written[wp] = 1'b1;
            wp++;
         end
      end
      return wp;
   endfunction

   function automatic logic [15:0] crc16_bytes(input logic [7:0] d [$], input int n);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int i = 0; i < n; i++) begin
         c = c ^ {d[i], 8'h00};
         for (int k = 0; k < 8; k++)
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic bit frame_predict(input cfr_pkg::req_type r,
                                        output cfr_pkg::rsp_type o);
      int dn, body, pos;
      logic [15:0] got, want, len;
      logic [7:0] dq [$];
      o = '0;
      if (r.mode == 1'b1) begin
         pos = cfr_pkg::HDR_BYTES + int'(r.payload_index);
         o.result_kind = cfr_pkg::KIND_READ;
         o.read_data = (pos < cfr_pkg::DECODED_DEPTH) ? dec_mem[pos] : 8'h00;
      end else if (r.line_byte != 8'h00) begin
         if (raw_fill < cfr_pkg::RAW_DEPTH) begin
            raw_mem[raw_fill] = r.line_byte;
            raw_fill++;
         end else raw_ovf = 1'b1;
         return 1'b0;
      end else if (raw_fill == 0) begin
         raw_ovf = 1'b0;
         return 1'b0;
      end else begin
         o.result_kind = cfr_pkg::KIND_STATUS;
         if (raw_ovf) begin
            o.status = cfr_pkg::ST_OVERFLOW;
            ovf_tot++;
         end else begin
            dn = unstuff_block();
            if (dn < cfr_pkg::MIN_FRAME) begin
               o.status = cfr_pkg::ST_COBS;
               cobs_tot++;
            end else begin
               body = dn - 2;
               for (int i = 0; i < body; i++) dq.push_back(dec_mem[i]);
               got  = {dec_mem[dn-1], dec_mem[dn-2]};
               want = crc16_bytes(dq, body);
               len  = {dec_mem[6], dec_mem[5]};
               if (got != want) o.status = cfr_pkg::ST_CRC;
               else if (int'(len) + cfr_pkg::HDR_BYTES != body) o.status = cfr_pkg::ST_LENGTH;
               else if (dec_mem[0] != version_reg) o.status = cfr_pkg::ST_VERSION;
               else o.status = cfr_pkg::ST_OK;
               if (o.status != cfr_pkg::ST_OK) check_tot++;
               else begin
                  ok_tot++;
                  o.frame_type     = dec_mem[1];
                  o.channel        = dec_mem[2];
                  o.sequence_res   = {dec_mem[4], dec_mem[3]};
                  o.payload_length = len[8:0];
               end
            end
         end
         raw_fill = 0;
         raw_ovf = 1'b0;
      end
      o.ok_count          = ok_tot;
      o.overflow_count    = ovf_tot;
      o.cobs_error_count  = cobs_tot;
      o.check_error_count = check_tot;
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] e,
                                       input logic [31:0] a);
      if (e !== a) begin
         $error("%s mismatch: expected %0h, got %0h", name, e, a);
         errors++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      cfr_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result: %p", rsp_item);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            check_field("result_kind", 32'(e.result_kind), 32'(rsp_item.result_kind));
            check_field("status", 32'(e.status), 32'(rsp_item.status));
            check_field("frame_type", 32'(e.frame_type), 32'(rsp_item.frame_type));
            check_field("channel", 32'(e.channel), 32'(rsp_item.channel));
            check_field("sequence_res", 32'(e.sequence_res), 32'(rsp_item.sequence_res));
            check_field("payload_length", 32'(e.payload_length),
                        32'(rsp_item.payload_length));
            check_field("read_data", 32'(e.read_data), 32'(rsp_item.read_data));
            check_field("ok_count", e.ok_count, rsp_item.ok_count);
            check_field("overflow_count", e.overflow_count, rsp_item.overflow_count);
            check_field("cobs_error_count", e.cobs_error_count, rsp_item.cobs_error_count);
            check_field("check_error_count", e.check_error_count,
                        rsp_item.check_error_count);
         end
      end
   end

   // receiver: long hold-off when asked, else alternating fast and choppy stretches
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         if ($urandom_range(0, 199) == 0) ready_fast = ~ready_fast;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (ready_fast) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic send_item(input cfr_pkg::req_type it);
      cfr_pkg::rsp_type o;
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      if (frame_predict(it, o)) expected_rsp.push_back(o);
      sent++;
      if (burst_left > 0) burst_left--;
      else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   task automatic send_line(input logic [7:0] b);
      cfr_pkg::req_type it;
      it.mode = 1'b0;
      it.line_byte = b;
      it.payload_index = 9'($urandom_range(0, 511));
      send_item(it);
   endtask

   task automatic send_read(input int idx);
      cfr_pkg::req_type it;
      if (cfr_pkg::HDR_BYTES + idx < cfr_pkg::DECODED_DEPTH
          && !dec_written[cfr_pkg::HDR_BYTES + idx])
         idx = 505 + $urandom_range(0, 6);
      it.mode = 1'b1;
      it.line_byte = 8'($urandom_range(0, 255));
      it.payload_index = 9'(idx);
      send_item(it);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_version(input logic [7:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      version_reg = v;
   endtask

   function automatic logic [7:0] rand_byte(input int zero_pct);
      if ($urandom_range(0, 99) < zero_pct) return 8'h00;
      return 8'($urandom_range(1, 255));
   endfunction

   task automatic send_frame(input logic [7:0] ver, input int n, input int len_adj,
                             input frame_kind_type kind, input int zero_pct);
      logic [7:0] d [$];
      logic [7:0] enc [$];
      logic [15:0] c, ln;
      int ci, code, k;
      ln = 16'(n + len_adj);
      d.push_back(ver);
      repeat (4) d.push_back(rand_byte(15));
      d.push_back(ln[7:0]);
      d.push_back(ln[15:8]);
      repeat (n) d.push_back(rand_byte(zero_pct));
      c = crc16_bytes(d, d.size());
      d.push_back(c[7:0]);
      d.push_back(c[15:8]);
      if (kind == FR_CRC) begin
         k = $urandom_range(0, d.size() - 1);
         d[k] = d[k] ^ 8'($urandom_range(1, 255));
      end else if (kind == FR_SHORT) d = d[0:$urandom_range(0, 7)];
      // standard byte stuffing
      ci = 0;
      code = 1;
      enc.push_back(8'h00);
      foreach (d[i]) begin
         if (d[i] == 8'h00) begin
            enc[ci] = 8'(code);
            ci = enc.size();
            enc.push_back(8'h00);
            code = 1;
         end else begin
            enc.push_back(d[i]);
            code++;
            if (code == 255) begin
               enc[ci] = 8'hFF;
               ci = enc.size();
               enc.push_back(8'h00);
               code = 1;
            end
         end
      end
      enc[ci] = 8'(code);
      if (kind == FR_TRUNC && enc.size() > 4) repeat ($urandom_range(1, 3)) void'(enc.pop_back());
      foreach (enc[i]) send_line(enc[i]);
      send_line(8'h00);
   endtask

   task automatic test_directed_frames();
      send_frame(8'd1, 0, 0, FR_GOOD, 20);
      send_frame(8'd1, 5, 0, FR_GOOD, 30);
      send_line(8'h00);                       // empty block: no result
      send_frame(8'd1, 300, 0, FR_GOOD, 0);   // long nonzero runs, 0xFF codes
      send_read(0);
      send_read(511);
      send_read(299);
   endtask

   task automatic test_error_frames();
      send_frame(8'd1, 4, 0, FR_CRC, 20);
      send_frame(8'd1, 4, 3, FR_GOOD, 20);    // length field off
      send_frame(8'd7, 4, 0, FR_GOOD, 20);    // wrong version
      send_frame(8'd1, 2, 0, FR_SHORT, 20);
      send_line(8'h05); send_line(8'h01); send_line(8'h02); send_line(8'h00);
      repeat (520) send_line(8'hFF);          // raw store overflow
      send_line(8'h00);
      send_line(8'h00);
      send_read(3);
   endtask

   task automatic test_version_extremes();
      set_version(8'd0);
      send_frame(8'd0, 3, 0, FR_GOOD, 25);
      send_frame(8'd1, 3, 0, FR_GOOD, 25);
      set_version(8'd255);
      send_frame(8'd255, 3, 0, FR_GOOD, 25);
      send_frame(8'd0, 3, 0, FR_GOOD, 25);
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_left = 3000;
      repeat (6) send_frame(version_reg, $urandom_range(0, 6), 0, FR_GOOD, 25);
      repeat (4) send_read($urandom_range(0, 6));
      wait_idle();
      send_frame(version_reg, 2, 0, FR_GOOD, 25);
   endtask

   task automatic test_random();
      int r, phase_mark;
      phase_mark = sent;
      while (sent < NUM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (sent - phase_mark > 400) begin
            set_version(8'($urandom_range(0, 255)));
            phase_mark = sent;
         end
         if (r < 55) begin
            if ($urandom_range(0, 29) == 0)
               send_frame(version_reg, $urandom_range(400, 503), 0, FR_GOOD, 10);
            else
               send_frame(version_reg, $urandom_range(0, 24), 0, FR_GOOD,
                          $urandom_range(0, 50));
         end else if (r < 60) send_frame(8'(version_reg + 8'd1), $urandom_range(0, 8), 0,
                                         FR_GOOD, 20);
         else if (r < 65) send_frame(version_reg, $urandom_range(0, 8),
                                     $urandom_range(1, 600), FR_GOOD, 20);
         else if (r < 70) send_frame(version_reg, $urandom_range(0, 12), 0, FR_CRC, 20);
         else if (r < 74) send_frame(version_reg, $urandom_range(0, 12), 0, FR_TRUNC, 20);
         else if (r < 77) send_frame(version_reg, 0, 0, FR_SHORT, 20);
         else if (r < 88) repeat ($urandom_range(1, 5)) send_read($urandom_range(0, 511));
         else if (r < 97) repeat ($urandom_range(1, 6)) send_line(rand_byte(30));
         else begin
            repeat ($urandom_range(513, 530)) send_line(8'($urandom_range(1, 255)));
            send_line(8'h00);
         end
      end
   endtask

   initial begin
      raw_fill = 0;
      raw_ovf = 1'b0;
      ok_tot = '0; ovf_tot = '0; cobs_tot = '0; check_tot = '0;
      version_reg = 8'd1;
      foreach (dec_written[i]) begin
         dec_written[i] = 1'b0;
         dec_mem[i] = 8'h00;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_frames();
      test_error_frames();
      test_version_extremes();
      set_version(8'd1);
      test_backpressure();
      test_random();
      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
